// File: design/clipped_color_key_tile_blit_macros.svh
// Assertion macros shared by the tile blitter RTL.
`ifndef CLIPPED_COLOR_KEY_TILE_BLIT_MACROS_SVH
`define CLIPPED_COLOR_KEY_TILE_BLIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCKB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cckb: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCKB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cckb: assertion failed");

`endif

// File: design/cckb_pkg.sv
// Shared constants and types of the clipped color-key tile blitter.
`default_nettype none

package cckb_pkg;

	// Fixed field widths
	localparam int ORIGIN_W   = 13;
	localparam int PIXEL_W    = 32;
	localparam int ADDR_W     = 24;
	localparam int TILE_REG_W = 7;
	localparam int STRIDE_W   = 13;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	// Register reset values
	localparam int RST_CLIP_LEFT   = 8;
	localparam int RST_CLIP_TOP    = 8;
	localparam int RST_CLIP_WIDTH  = 288;
	localparam int RST_CLIP_HEIGHT = 288;
	localparam int RST_TILE_WIDTH  = 32;
	localparam int RST_TILE_HEIGHT = 32;
	localparam int RST_ROW_STRIDE  = 640;
	localparam int RST_COLOR_KEY   = 0;

	// Queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLIP_LEFT   = 3'd0,
		CFG_CLIP_TOP    = 3'd1,
		CFG_CLIP_WIDTH  = 3'd2,
		CFG_CLIP_HEIGHT = 3'd3,
		CFG_TILE_WIDTH  = 3'd4,
		CFG_TILE_HEIGHT = 3'd5,
		CFG_ROW_STRIDE  = 3'd6,
		CFG_COLOR_KEY   = 3'd7
	} cfg_idx_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

`default_nettype wire

// File: design/cckb_intf.sv
// Handshake channels of the tile blitter: source pixels in, frame buffer writes out.
`default_nettype none

interface cckb_src_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [cckb_pkg::ORIGIN_W-1:0]  origin_x;
	logic signed [cckb_pkg::ORIGIN_W-1:0]  origin_y;
	logic                                  keyed;
	logic        [cckb_pkg::PIXEL_W-1:0]   src_pixel;

	modport source (output valid, origin_x, origin_y, keyed, src_pixel, input ready);
	modport sink   (input valid, origin_x, origin_y, keyed, src_pixel, output ready);
endinterface

interface cckb_dst_if;
	logic                             valid;
	logic                             ready;
	logic [cckb_pkg::ADDR_W-1:0]      dest_address;
	logic [cckb_pkg::PIXEL_W-1:0]     dest_pixel;

	modport source (output valid, dest_address, dest_pixel, input ready);
	modport sink   (input valid, dest_address, dest_pixel, output ready);
endinterface

`default_nettype wire

// File: design/cckb_front.sv
// Front end: takes source words, tracks tile position, clips and keys each pixel.
`default_nettype none

module cckb_front #(
	parameter int COORD_BITS   = 12,
	parameter int TILE_DIM_MAX = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	cckb_src_if.sink                            src,
	input  logic [COORD_BITS-1:0]               clip_left,
	input  logic [COORD_BITS-1:0]               clip_top,
	input  logic [COORD_BITS-1:0]               clip_width,
	input  logic [COORD_BITS-1:0]               clip_height,
	input  logic [cckb_pkg::TILE_REG_W-1:0]     tile_width,
	input  logic [cckb_pkg::TILE_REG_W-1:0]     tile_height,
	input  logic [cckb_pkg::PIXEL_W-1:0]        color_key,
	input  cckb_pkg::fifo_stat_t                fifo_stat,
	output logic                                push,
	output logic [COORD_BITS:0]                 push_x,
	output logic [COORD_BITS:0]                 push_y,
	output logic [cckb_pkg::PIXEL_W-1:0]        push_pixel
);

	`include "clipped_color_key_tile_blit_macros.svh"

	localparam int CNT_W = (TILE_DIM_MAX > 1) ? $clog2(TILE_DIM_MAX) : 1;
	localparam int NX_W  = (CNT_W + 1 > cckb_pkg::TILE_REG_W) ? CNT_W + 1
		: cckb_pkg::TILE_REG_W;
	// signed room for origin plus tile offset and for the clip right edge
	localparam int CMP_W = (COORD_BITS + 2 > cckb_pkg::ORIGIN_W + 2) ? COORD_BITS + 2
		: cckb_pkg::ORIGIN_W + 2;

	logic [CNT_W-1:0]                     col_q, row_q;
	logic signed [cckb_pkg::ORIGIN_W-1:0] lx_q, ly_q;
	logic                                 lkeyed_q;

	logic                                 first, accept, key_hit, in_x, in_y;
	logic                                 col_wrap, row_wrap;
	logic signed [cckb_pkg::ORIGIN_W-1:0] cur_x, cur_y;
	logic                                 cur_keyed;
	logic signed [CMP_W-1:0]              pos_x, pos_y, lo_x, hi_x, lo_y, hi_y;
	logic [NX_W-1:0]                      col_nx, row_nx;

	// Origin and mode come from the word itself at the tile's first pixel
	always_comb begin
		first     = (col_q == '0) && (row_q == '0);
		cur_x     = first ? src.origin_x : lx_q;
		cur_y     = first ? src.origin_y : ly_q;
		cur_keyed = first ? src.keyed : lkeyed_q;
	end

	// Screen position and clip test
	always_comb begin
		pos_x = CMP_W'(cur_x) + $signed(CMP_W'(col_q));
		pos_y = CMP_W'(cur_y) + $signed(CMP_W'(row_q));
		lo_x  = $signed(CMP_W'(clip_left));
		lo_y  = $signed(CMP_W'(clip_top));
		hi_x  = lo_x + $signed(CMP_W'(clip_width));
		hi_y  = lo_y + $signed(CMP_W'(clip_height));
		in_x  = (pos_x >= lo_x) && (pos_x < hi_x);
		in_y  = (pos_y >= lo_y) && (pos_y < hi_y);
		key_hit = cur_keyed && (src.src_pixel == color_key);
	end

	// Handshake and queue push
	assign src.ready  = !fifo_stat.full;
	assign accept     = src.valid && src.ready;
	assign push       = accept && in_x && in_y && !key_hit;
	assign push_x     = pos_x[COORD_BITS:0];
	assign push_y     = pos_y[COORD_BITS:0];
	assign push_pixel = src.src_pixel;

	// Wrap checks; a size of zero wraps every step, above the maximum wraps at it
	always_comb begin
		col_nx   = NX_W'(col_q) + NX_W'(1);
		row_nx   = NX_W'(row_q) + NX_W'(1);
		col_wrap = (col_nx >= NX_W'(tile_width)) || (col_nx >= NX_W'(TILE_DIM_MAX));
		row_wrap = (row_nx >= NX_W'(tile_height)) || (row_nx >= NX_W'(TILE_DIM_MAX));
	end

	// Position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_nx[CNT_W-1:0];
			end else begin
				col_q <= col_nx[CNT_W-1:0];
			end
		end
	end

	// Tile origin and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q     <= '0;
			ly_q     <= '0;
			lkeyed_q <= 1'b0;
		end else if (accept && first) begin
			lx_q     <= src.origin_x;
			ly_q     <= src.origin_y;
			lkeyed_q <= src.keyed;
		end
	end

	`CCKB_ASSERT_NEXT(a_origin_latched, clk, arst_n, accept && first, lx_q == $past(src.origin_x) && lkeyed_q == $past(src.keyed))

endmodule

`default_nettype wire

// File: design/cckb_fifo.sv
// Short queue of clipped pixels between front and back.
`default_nettype none

module cckb_fifo #(
	parameter int WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      wr_data,
	input  logic                  pop,
	output logic [WIDTH-1:0]      rd_data,
	output cckb_pkg::fifo_stat_t  stat
);

	`include "clipped_color_key_tile_blit_macros.svh"

	logic [WIDTH-1:0]                  mem [cckb_pkg::FIFO_DEPTH];
	logic [cckb_pkg::FIFO_PTR_W-1:0]   wr_q, rd_q;
	logic [cckb_pkg::FIFO_CNT_W-1:0]   cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == cckb_pkg::FIFO_CNT_W'(cckb_pkg::FIFO_DEPTH));
	assign rd_data    = mem[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`CCKB_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !stat.full)
	`CCKB_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, !stat.empty)

endmodule

`default_nettype wire

// File: design/cckb_back.sv
// Back end: row multiply, address add and output register.
`default_nettype none

module cckb_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cckb_pkg::fifo_stat_t              fifo_stat,
	output logic                              pop,
	input  logic [COORD_BITS:0]               head_x,
	input  logic [COORD_BITS:0]               head_y,
	input  logic [cckb_pkg::PIXEL_W-1:0]      head_pixel,
	input  logic [cckb_pkg::STRIDE_W-1:0]     row_stride,
	cckb_dst_if.source                        dst
);

	`include "clipped_color_key_tile_blit_macros.svh"

	localparam int PROD_W = COORD_BITS + 1 + cckb_pkg::STRIDE_W;

	logic                            v_s1, v_s2;
	logic                            adv_s1, adv_s2;
	logic [PROD_W-1:0]               prod;
	logic [cckb_pkg::ADDR_W-1:0]     prod_s1, x_s1, addr_s2;
	logic [cckb_pkg::PIXEL_W-1:0]    pixel_s1, pixel_s2;

	// Stage advance
	assign adv_s2 = !v_s2 || dst.ready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign pop    = !fifo_stat.empty && adv_s1;
	assign prod   = PROD_W'(head_y) * PROD_W'(row_stride);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= !fifo_stat.empty;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1: y times stride
	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1  <= cckb_pkg::ADDR_W'(prod);
			x_s1     <= cckb_pkg::ADDR_W'(head_x);
			pixel_s1 <= head_pixel;
		end
	end

	// Stage 2: add column, hold for the sink
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			addr_s2  <= prod_s1 + x_s1;
			pixel_s2 <= pixel_s1;
		end
	end

	assign dst.valid        = v_s2;
	assign dst.dest_address = addr_s2;
	assign dst.dest_pixel   = pixel_s2;

	`CCKB_ASSERT_NEXT(a_s1_hold, clk, arst_n, v_s1 && !adv_s1, v_s1 && $stable(prod_s1) && $stable(x_s1))

endmodule

`default_nettype wire

// File: design/clipped_color_key_tile_blit.sv
// Top level of the clipped color-key tile blitter: register file and the front/back pipeline.
`default_nettype none

// Takes one source pixel word per clock in tile raster order while the queue has room and
// emits one frame buffer write for every pixel that lands inside the clip window and, in
// keyed mode, differs from the color key; other pixels are dropped silently. Origin and
// keyed mode are taken from the first word of each tile only. Sustained rate is one word
// per cycle while dst does not stall. A kept pixel is written into the four-entry queue by
// the front clip test at the edge that takes it, then loaded by the row multiply stage and
// then by the address adder and output register, which presents it on dst. While dst
// stalls, the output register, the multiply stage and the queue together hold up to six
// kept pixels before src.ready drops; dropped pixels take no room. The user must write
// registers through cfg_we/cfg_index/cfg_data only while the block is idle; the block
// itself does not enforce this.
module clipped_color_key_tile_blit #(
	parameter int TILE_DIM_MAX = 64,
	parameter int COORD_BITS   = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cckb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cckb_pkg::CFG_DATA_W-1:0]    cfg_data,
	cckb_src_if.sink                           src,
	cckb_dst_if.source                         dst
);

	localparam int XY_W    = COORD_BITS + 1;
	localparam int ENTRY_W = 2 * XY_W + cckb_pkg::PIXEL_W;

	logic [COORD_BITS-1:0]               clip_left_q, clip_top_q, clip_width_q, clip_height_q;
	logic [cckb_pkg::TILE_REG_W-1:0]     tile_width_q, tile_height_q;
	logic [cckb_pkg::STRIDE_W-1:0]       row_stride_q;
	logic [cckb_pkg::PIXEL_W-1:0]        color_key_q;

	logic                                push, pop;
	logic [XY_W-1:0]                     push_x, push_y;
	logic [cckb_pkg::PIXEL_W-1:0]        push_pixel;
	logic [ENTRY_W-1:0]                  rd_data;
	cckb_pkg::fifo_stat_t                fifo_stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= COORD_BITS'(cckb_pkg::RST_CLIP_LEFT);
			clip_top_q    <= COORD_BITS'(cckb_pkg::RST_CLIP_TOP);
			clip_width_q  <= COORD_BITS'(cckb_pkg::RST_CLIP_WIDTH);
			clip_height_q <= COORD_BITS'(cckb_pkg::RST_CLIP_HEIGHT);
			tile_width_q  <= cckb_pkg::TILE_REG_W'(cckb_pkg::RST_TILE_WIDTH);
			tile_height_q <= cckb_pkg::TILE_REG_W'(cckb_pkg::RST_TILE_HEIGHT);
			row_stride_q  <= cckb_pkg::STRIDE_W'(cckb_pkg::RST_ROW_STRIDE);
			color_key_q   <= cckb_pkg::PIXEL_W'(cckb_pkg::RST_COLOR_KEY);
		end else if (cfg_we) begin
			case (cckb_pkg::cfg_idx_t'(cfg_index))
				cckb_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_data[COORD_BITS-1:0];
				cckb_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_data[COORD_BITS-1:0];
				cckb_pkg::CFG_CLIP_WIDTH:  clip_width_q  <= cfg_data[COORD_BITS-1:0];
				cckb_pkg::CFG_CLIP_HEIGHT: clip_height_q <= cfg_data[COORD_BITS-1:0];
				cckb_pkg::CFG_TILE_WIDTH:  tile_width_q  <= cfg_data[cckb_pkg::TILE_REG_W-1:0];
				cckb_pkg::CFG_TILE_HEIGHT: tile_height_q <= cfg_data[cckb_pkg::TILE_REG_W-1:0];
				cckb_pkg::CFG_ROW_STRIDE:  row_stride_q  <= cfg_data[cckb_pkg::STRIDE_W-1:0];
				cckb_pkg::CFG_COLOR_KEY:   color_key_q   <= cfg_data[cckb_pkg::PIXEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: position tracking, clip and key
	cckb_front #(
		.COORD_BITS   (COORD_BITS),
		.TILE_DIM_MAX (TILE_DIM_MAX)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.src         (src),
		.clip_left   (clip_left_q),
		.clip_top    (clip_top_q),
		.clip_width  (clip_width_q),
		.clip_height (clip_height_q),
		.tile_width  (tile_width_q),
		.tile_height (tile_height_q),
		.color_key   (color_key_q),
		.fifo_stat   (fifo_stat),
		.push        (push),
		.push_x      (push_x),
		.push_y      (push_y),
		.push_pixel  (push_pixel)
	);

	// Queue of kept pixels
	cckb_fifo #(
		.WIDTH (ENTRY_W)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({push_y, push_x, push_pixel}),
		.pop     (pop),
		.rd_data (rd_data),
		.stat    (fifo_stat)
	);

	// Back: address generation and output
	cckb_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_stat  (fifo_stat),
		.pop        (pop),
		.head_x     (rd_data[cckb_pkg::PIXEL_W +: XY_W]),
		.head_y     (rd_data[cckb_pkg::PIXEL_W + XY_W +: XY_W]),
		.head_pixel (rd_data[cckb_pkg::PIXEL_W-1:0]),
		.row_stride (row_stride_q),
		.dst        (dst)
	);

endmodule

`default_nettype wire
